### rtl/assert_macros.svh
// Assertion macros used by the ARP reply checker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while reset is asserted.
`define ARC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define ARC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/arp_rc_pkg.sv
// Package with constants, codes and types of the ARP reply checker.
`timescale 1ns / 1ps

package arp_rc_pkg;

  // Byte counter saturates at this value.
  localparam int COUNT_LIMIT = 1023;
  localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PROBED_IP = CFG_IDX_W'(1);

  // ARP protocol constants.
  localparam logic [15:0] OPCODE_REQUEST = 16'd1;
  localparam logic [15:0] OPCODE_REPLY   = 16'd2;
  localparam logic [15:0] HW_TYPE_ETHER  = 16'd1;
  localparam logic [15:0] HW_TYPE_FDDI   = 16'd774;
  localparam logic [15:0] PROTO_IPV4     = 16'h0800;
  localparam logic [7:0]  IPV4_ADDR_LEN  = 8'd4;

  // Byte offsets in the ARP header.
  localparam int OFF_PROTO  = 2;
  localparam int OFF_HLN    = 4;
  localparam int OFF_PLN    = 5;
  localparam int OFF_OPCODE = 6;
  localparam int OFF_ADDR   = 8;
  // Target address starts at 12 + 2*HLN; a full packet is 16 + 2*HLN bytes.
  localparam int OFF_TARGET = 12;
  localparam int MIN_BASE   = 16;

  // Highest link packet class that is addressed to this host.
  localparam logic [2:0] CLASS_MAX_OK = 3'd2;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_CLASS    = 3'd1,
    VERDICT_OPCODE   = 3'd2,
    VERDICT_HWTYPE   = 3'd3,
    VERDICT_PROTO    = 3'd4,
    VERDICT_PLEN     = 3'd5,
    VERDICT_SHORT    = 3'd6,
    VERDICT_ADDRESS  = 3'd7
  } verdict_t;

  // Header fields gathered while a packet streams in.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [15:0]      hw_fmt;
    logic [15:0]      proto_fmt;
    logic [7:0]       hln;
    logic [7:0]       pln;
    logic [15:0]      opcode;
    logic [31:0]      sender;
    logic [31:0]      target;
  } arp_fields_t;

endpackage

### rtl/arp_rc_in_if.sv
// Input channel of the ARP reply checker: one packet byte per transaction.
`timescale 1ns / 1ps

interface arp_rc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pkt_byte;
  logic        last_byte;
  logic [2:0]  link_pkt_class;
  logic [15:0] link_hw_type;

  modport source (output valid, pkt_byte, last_byte, link_pkt_class, link_hw_type,
                  input ready);
  modport sink (input valid, pkt_byte, last_byte, link_pkt_class, link_hw_type,
                output ready);
endinterface

### rtl/arp_rc_out_if.sv
// Result channel of the ARP reply checker: one verdict per packet.
`timescale 1ns / 1ps

interface arp_rc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [31:0] reply_sender_ip;

  modport source (output valid, verdict, reply_sender_ip, input ready);
  modport sink (input valid, verdict, reply_sender_ip, output ready);
endinterface

### rtl/arp_rc_parse.sv
// Header field capture and saturating byte counter of the ARP reply checker.
`timescale 1ns / 1ps

module arp_rc_parse import arp_rc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  pkt_byte,
  input  logic        last_byte,
  output arp_fields_t fields_upd
);

  arp_fields_t      cur_r;
  arp_fields_t      cur_nxt;
  arp_fields_t      upd;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] s0;
  logic [CNT_W-1:0] t0;

  // Fields as they stand once the current byte is taken in.
  always_comb begin
    upd = cur_r;
    pos = cur_r.count;
    s0  = CNT_W'(OFF_ADDR) + CNT_W'(cur_r.hln);
    t0  = CNT_W'(OFF_TARGET) + CNT_W'({cur_r.hln, 1'b0});
    if (cur_r.count < CNT_W'(COUNT_LIMIT)) begin
      if (pos < CNT_W'(OFF_PROTO)) begin
        upd.hw_fmt = {cur_r.hw_fmt[7:0], pkt_byte};
      end else if (pos < CNT_W'(OFF_HLN)) begin
        upd.proto_fmt = {cur_r.proto_fmt[7:0], pkt_byte};
      end else if (pos == CNT_W'(OFF_HLN)) begin
        upd.hln = pkt_byte;
      end else if (pos == CNT_W'(OFF_PLN)) begin
        upd.pln = pkt_byte;
      end else if (pos < CNT_W'(OFF_ADDR)) begin
        upd.opcode = {cur_r.opcode[7:0], pkt_byte};
      end else if (pos >= s0 && pos < s0 + CNT_W'(4)) begin
        upd.sender = {cur_r.sender[23:0], pkt_byte};
      end else if (pos >= t0 && pos < t0 + CNT_W'(4)) begin
        upd.target = {cur_r.target[23:0], pkt_byte};
      end
      upd.count = cur_r.count + CNT_W'(1);
    end
  end

  // The last byte of a packet leaves everything cleared for the next one.
  always_comb begin
    cur_nxt = cur_r;
    if (step) begin
      cur_nxt = last_byte ? '0 : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

  assign fields_upd = upd;

endmodule

### rtl/arp_rc_judge.sv
// Ordered verdict checks of the ARP reply checker.
`timescale 1ns / 1ps

module arp_rc_judge import arp_rc_pkg::*; (
  input  arp_fields_t fields,
  input  logic [2:0]  link_pkt_class,
  input  logic [15:0] link_hw_type,
  input  logic [31:0] own_ip,
  input  logic [31:0] probed_ip,
  output verdict_t    verdict
);

  logic [CNT_W-1:0] min_len;
  logic             hw_ok;

  assign min_len = CNT_W'(MIN_BASE) + CNT_W'({fields.hln, 1'b0});

  // An FDDI interface also carries Ethernet-typed ARP.
  assign hw_ok = (fields.hw_fmt == link_hw_type) ||
                 (link_hw_type == HW_TYPE_FDDI && fields.hw_fmt == HW_TYPE_ETHER);

  // First failing check wins.
  always_comb begin
    if (link_pkt_class > CLASS_MAX_OK) begin
      verdict = VERDICT_CLASS;
    end else if (fields.opcode != OPCODE_REQUEST && fields.opcode != OPCODE_REPLY) begin
      verdict = VERDICT_OPCODE;
    end else if (!hw_ok) begin
      verdict = VERDICT_HWTYPE;
    end else if (fields.proto_fmt != PROTO_IPV4) begin
      verdict = VERDICT_PROTO;
    end else if (fields.pln != IPV4_ADDR_LEN) begin
      verdict = VERDICT_PLEN;
    end else if (fields.count < min_len) begin
      verdict = VERDICT_SHORT;
    end else if (fields.sender != probed_ip || fields.target != own_ip) begin
      verdict = VERDICT_ADDRESS;
    end else begin
      verdict = VERDICT_OK;
    end
  end

endmodule

### rtl/arp_reply_checker.sv
// Top level of the ARP reply checker: input register, parser, checks, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The checker takes a received ARP packet one byte per transaction on in_ch, in
// network order, with the link packet class and interface hardware type valid on
// the transaction marked last_byte. It accepts one byte every cycle unless a
// last byte is held in the input register. Each byte first lands in an input
// register; from there the parser takes it into the header fields (hardware
// type, protocol type, address lengths, opcode and the sender and target IPv4
// addresses, whose offsets follow the hardware address length) and, for the
// last byte, the ordered checks form the verdict that is loaded into the result
// register, which drives out_ch. Only the last byte of a packet yields a
// result transaction; the verdict codes are 0 ok, 1 foreign packet class,
// 2 opcode neither request nor reply, 3 hardware type mismatch, 4 protocol not
// IPv4, 5 protocol address length not 4, 6 packet too short, 7 sender differs
// from probed_ip or target differs from own_ip. The result also carries the
// sender address latched from the packet, zero if its bytes never arrived. The
// byte counter saturates at COUNT_LIMIT, and bytes past the address fields are
// ignored. While a result waits on out_ch, non-final bytes keep flowing; only a
// last byte waits in the input register, and the input stalls behind it until
// the waiting result is taken. Configuration is a plain write port: cfg_index 0
// writes own_ip and 1 writes probed_ip, other indexes are ignored, and writes are
// meant to happen only while no packet is in flight.

module arp_reply_checker import arp_rc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  arp_rc_in_if.sink             in_ch,
  arp_rc_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [31:0] own_ip_r;
  logic [31:0] probed_ip_r;

  // Input register stage.
  logic        s1_v_r;
  logic        s1_v_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [2:0]  s1_cls_r;
  logic [15:0] s1_hw_r;

  // Result register.
  logic        out_v_r;
  logic        out_v_nxt;
  verdict_t    out_verdict_r;
  logic [31:0] out_sender_r;

  logic        in_accept;
  logic        advance;
  logic        out_load;
  arp_fields_t fields_upd;
  verdict_t    verdict;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r    <= '0;
      probed_ip_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_IP:    own_ip_r    <= cfg_wdata[31:0];
        CFG_PROBED_IP: probed_ip_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // A buffered byte moves on unless it is a last byte and the result register
  // is still holding an untaken verdict.
  assign advance   = s1_v_r && (!s1_last_r || !out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || advance;
  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_load  = advance && s1_last_r;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_accept) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_ch.pkt_byte;
      s1_last_r <= in_ch.last_byte;
      s1_cls_r  <= in_ch.link_pkt_class;
      s1_hw_r   <= in_ch.link_hw_type;
    end
    if (out_load) begin
      out_verdict_r <= verdict;
      out_sender_r  <= fields_upd.sender;
    end
  end

  arp_rc_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .pkt_byte   (s1_byte_r),
    .last_byte  (s1_last_r),
    .fields_upd (fields_upd)
  );

  arp_rc_judge u_judge (
    .fields         (fields_upd),
    .link_pkt_class (s1_cls_r),
    .link_hw_type   (s1_hw_r),
    .own_ip         (own_ip_r),
    .probed_ip      (probed_ip_r),
    .verdict        (verdict)
  );

  assign out_ch.valid           = out_v_r;
  assign out_ch.verdict         = out_verdict_r;
  assign out_ch.reply_sender_ip = out_sender_r;

  // A new result only ever follows a last byte leaving the input register.
  `ARC_ASSERT(a_result_from_last, $rose(out_v_r) |-> $past(s1_v_r && s1_last_r), "result without last byte")
  // A last byte waits in the input register while the previous verdict is stalled.
  `ARC_ASSERT(a_last_holds, (s1_v_r && s1_last_r && out_v_r && !out_ch.ready) |=> (s1_v_r && s1_last_r && $stable(s1_byte_r)), "last byte lost while result stalled")
  // Reset empties both pipeline registers.
  `ARC_ASSERT_NR(a_reset_empty, !rst_n |=> (!s1_v_r && !out_v_r), "pipeline not empty after reset")

endmodule

### verif/testbench.sv
// Self-checking testbench for the ARP reply checker, with a byte-level parser model.
`timescale 1ns / 1ps

// The bench streams ARP packets into the checker one byte per input transaction.
// An independent parser model in this file mirrors the header latching and the
// ordered verdict checks, and it queues one expected verdict for every last byte
// that the block accepts. Each result transaction is then compared, field by
// field, with the oldest queued verdict.
//
// The run has four parts. A short directed table covers the extreme field values,
// a foreign packet class, a bad opcode, a short packet, and a full valid reply
// that relies on the FDDI hardware type allowance and uses the reset register
// values. Three random phases follow. The first lets the sender idle lightly and
// the receiver heavily, the second swaps the two, and the third idles neither
// side. Before each random phase the registers are rewritten while the block is
// idle, and each rewrite includes writes to the unused register indexes. The
// third phase also holds the result channel off for a long stretch while single
// byte packets keep arriving. It then sends one packet that is long enough to
// saturate the byte counter.

module testbench;
  import arp_rc_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 5;
  // A verdict passes only the input register and the result register after its
  // last byte, so this drain is enough for the pipeline to empty.
  localparam int DRAIN_CYCLES  = 4;
  localparam int HOLD_CYCLES   = 400;
  localparam int PRESSURE_PKTS = 40;
  localparam int PHASE_BYTES   = 320;
  localparam int FINAL_BYTES   = 1200;
  localparam int CYCLE_LIMIT   = 400000;

  // These register indexes have no register behind them. Writes to them must not
  // disturb the two address registers.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  // One input transaction, which carries one packet byte and its link metadata.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [2:0]  pkt_class;
    logic [15:0] link_hw;
  } arp_byte_t;

  // One result transaction.
  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] sender_ip;
  } arp_verdict_t;

  // One row of the directed table. The expected verdict is typed in only where
  // the typed flag is set.
  typedef struct packed {
    arp_byte_t    stim;
    logic         typed;
    arp_verdict_t want;
  } dir_row_t;

  localparam arp_verdict_t NO_RESULT = '{VERDICT_OK, 32'h0};
  localparam int DIR_ROWS = 26;

  // The table holds these packets in order: a single 0xFF byte of a foreign
  // class, a single zero byte with opcode zero, an 8-byte header that stops
  // before the addresses, and a full 16-byte reply with a zero hardware address
  // length. The full reply matches the reset register values and passes on an
  // FDDI link.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{8'hFF, 1'b1, 3'd7, 16'hFFFF}, 1'b1, '{VERDICT_CLASS, 32'h0}},
    '{'{8'h00, 1'b1, 3'd0, 16'h0000}, 1'b1, '{VERDICT_OPCODE, 32'h0}},
    '{'{8'h00, 1'b0, 3'd5, 16'hA5A5}, 1'b0, NO_RESULT},
    '{'{8'h01, 1'b0, 3'd2, 16'h5A5A}, 1'b0, NO_RESULT},
    '{'{8'h08, 1'b0, 3'd7, 16'hFFFF}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd0, 16'h0000}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd1, 16'h0306}, 1'b0, NO_RESULT},
    '{'{8'h04, 1'b0, 3'd3, 16'h0001}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd6, 16'h8000}, 1'b0, NO_RESULT},
    '{'{8'h01, 1'b1, 3'd1, HW_TYPE_ETHER}, 1'b1, '{VERDICT_SHORT, 32'h0}},
    '{'{8'h00, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h01, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h08, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h04, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h02, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0, 3'd4, 16'h1234}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b1, 3'd2, HW_TYPE_FDDI}, 1'b1, '{VERDICT_OK, 32'h0}}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  arp_rc_in_if  in_ch ();
  arp_rc_out_if out_ch ();

  arp_reply_checker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // This is the state of the parser model. It holds the header fields that have
  // been gathered so far and the two address registers.
  arp_fields_t  rx_hdr = '0;
  logic [31:0]  own_ip = '0;
  logic [31:0]  probed_ip = '0;
  arp_verdict_t pending_verdicts [$];
  arp_byte_t    packet_bytes [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req_seq = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // The model takes one accepted byte. It returns 1 and the expected verdict when
  // the byte closes the packet. The sender and target addresses sit after the
  // hardware addresses, so their offsets move with the hardware address length.
  function automatic bit arp_parse_byte(input arp_byte_t b, output arp_verdict_t res);
    int pos;
    int s0;
    int t0;
    res = NO_RESULT;
    pos = rx_hdr.count;
    s0  = OFF_ADDR + rx_hdr.hln;
    t0  = OFF_TARGET + 2 * rx_hdr.hln;
    if (pos < COUNT_LIMIT) begin
      if (pos < OFF_PROTO) begin
        rx_hdr.hw_fmt = {rx_hdr.hw_fmt[7:0], b.data};
      end else if (pos < OFF_HLN) begin
        rx_hdr.proto_fmt = {rx_hdr.proto_fmt[7:0], b.data};
      end else if (pos == OFF_HLN) begin
        rx_hdr.hln = b.data;
      end else if (pos == OFF_PLN) begin
        rx_hdr.pln = b.data;
      end else if (pos < OFF_ADDR) begin
        rx_hdr.opcode = {rx_hdr.opcode[7:0], b.data};
      end else if (pos >= s0 && pos < s0 + 4) begin
        rx_hdr.sender = {rx_hdr.sender[23:0], b.data};
      end else if (pos >= t0 && pos < t0 + 4) begin
        rx_hdr.target = {rx_hdr.target[23:0], b.data};
      end
      rx_hdr.count = rx_hdr.count + 1'b1;
    end
    if (!b.last) return 1'b0;

    // The checks run in order, and the first one that fails sets the verdict.
    if (b.pkt_class > CLASS_MAX_OK) begin
      res.verdict = VERDICT_CLASS;
    end else if (rx_hdr.opcode != OPCODE_REQUEST && rx_hdr.opcode != OPCODE_REPLY) begin
      res.verdict = VERDICT_OPCODE;
    end else if (rx_hdr.hw_fmt != b.link_hw &&
                 !(b.link_hw == HW_TYPE_FDDI && rx_hdr.hw_fmt == HW_TYPE_ETHER)) begin
      res.verdict = VERDICT_HWTYPE;
    end else if (rx_hdr.proto_fmt != PROTO_IPV4) begin
      res.verdict = VERDICT_PROTO;
    end else if (rx_hdr.pln != IPV4_ADDR_LEN) begin
      res.verdict = VERDICT_PLEN;
    end else if (int'(rx_hdr.count) < MIN_BASE + 2 * int'(rx_hdr.hln)) begin
      res.verdict = VERDICT_SHORT;
    end else if (rx_hdr.sender != probed_ip || rx_hdr.target != own_ip) begin
      res.verdict = VERDICT_ADDRESS;
    end else begin
      res.verdict = VERDICT_OK;
    end
    res.sender_ip = rx_hdr.sender;
    rx_hdr = '0;
    return 1'b1;
  endfunction

  // This builds one random packet in packet_bytes. Most packets are well-formed
  // requests or replies whose addresses mostly match the registers. About a fifth
  // have one header field corrupted or are cut short, and a tenth are plain
  // noise. Bytes before the last one carry random link metadata, which the block
  // must ignore. If min_len is set, the packet is well-formed and padded to at
  // least that many bytes.
  function automatic void build_packet(input bit single, input int min_len);
    logic [7:0]  raw [$];
    logic [15:0] hw_t;
    logic [15:0] link_hw;
    logic [15:0] op;
    logic [31:0] sip;
    logic [31:0] tip;
    logic [2:0]  cls;
    arp_byte_t   b;
    int pick;
    int hln;
    int n;
    int k;
    pick = (min_len > 0) ? 0 : $urandom_range(99);
    cls  = ($urandom_range(9) != 0) ? 3'($urandom_range(2)) : 3'($urandom_range(7, 3));
    case ($urandom_range(2))
      0: begin
        hw_t = HW_TYPE_ETHER;
        link_hw = HW_TYPE_ETHER;
      end
      1: begin
        hw_t = HW_TYPE_ETHER;
        link_hw = HW_TYPE_FDDI;
      end
      default: begin
        hw_t = 16'($urandom);
        link_hw = hw_t;
      end
    endcase
    // Hardware addresses are mostly short. Once in a while a long one pushes the
    // target address far into the packet.
    hln = ($urandom_range(32) != 0) ? $urandom_range(8) : $urandom_range(255, 9);
    op  = ($urandom_range(1) != 0) ? OPCODE_REPLY : OPCODE_REQUEST;
    sip = ($urandom_range(9) != 0) ? probed_ip : 32'($urandom);
    tip = ($urandom_range(9) != 0) ? own_ip : 32'($urandom);

    raw = '{hw_t[15:8], hw_t[7:0], PROTO_IPV4[15:8], PROTO_IPV4[7:0], 8'(hln),
            IPV4_ADDR_LEN, op[15:8], op[7:0]};
    repeat (hln) raw.push_back(8'($urandom));
    for (k = 24; k >= 0; k -= 8) raw.push_back(sip[k +: 8]);
    repeat (hln) raw.push_back(8'($urandom));
    for (k = 24; k >= 0; k -= 8) raw.push_back(tip[k +: 8]);
    repeat ($urandom_range(3)) raw.push_back(8'($urandom));

    if (single || pick >= 90) begin
      raw.delete();
      n = single ? 1 : $urandom_range(40, 1);
      repeat (n) raw.push_back(8'($urandom));
      cls = 3'($urandom);
      link_hw = 16'($urandom);
    end else if (pick >= 70) begin
      case ($urandom_range(4))
        0: begin
          raw[OFF_OPCODE] = 8'($urandom);
          raw[OFF_OPCODE + 1] = 8'($urandom);
        end
        1: begin
          raw[0] = 8'($urandom);
          raw[1] = 8'($urandom);
        end
        2: begin
          raw[OFF_PROTO] = 8'($urandom);
          raw[OFF_PROTO + 1] = 8'($urandom);
        end
        3: raw[OFF_PLN] = 8'($urandom);
        default: begin
          n = $urandom_range(raw.size() - 1, 1);
          while (raw.size() > n) void'(raw.pop_back());
        end
      endcase
    end
    while (raw.size() < min_len) raw.push_back(8'($urandom));

    packet_bytes.delete();
    for (k = 0; k < raw.size(); k++) begin
      b.data      = raw[k];
      b.last      = (k == raw.size() - 1);
      b.pkt_class = b.last ? cls : 3'($urandom);
      b.link_hw   = b.last ? link_hw : 16'($urandom);
      packet_bytes.push_back(b);
    end
  endfunction

  // This offers one byte and waits until the block accepts it. Valid stays high
  // from one byte to the next unless the sender picks an idle cycle. Once the
  // byte is accepted it goes to the parser model. A packet end queues either the
  // model's verdict or, for directed rows, the verdict typed in the table.
  task automatic send_byte(input arp_byte_t b, input bit typed, input arp_verdict_t want);
    arp_verdict_t got;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.pkt_byte       <= b.data;
    in_ch.last_byte      <= b.last;
    in_ch.link_pkt_class <= b.pkt_class;
    in_ch.link_hw_type   <= b.link_hw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (arp_parse_byte(b, got)) pending_verdicts.push_back(typed ? want : got);
  endtask

  task automatic send_random_packet(input bit single, input int min_len, inout int sent);
    int k;
    build_packet(single, min_len);
    for (k = 0; k < packet_bytes.size(); k++) send_byte(packet_bytes[k], 1'b0, NO_RESULT);
    sent += packet_bytes.size();
  endtask

  // This runs one random phase. Every phase ends on a last byte, so the block
  // holds no partial packet when the registers are rewritten afterward.
  task automatic run_packets(input int byte_budget, input bit pressure, input bit saturate);
    int sent;
    sent = 0;
    if (pressure) begin
      // This asks the receiver to hold off for a long stretch. The single-byte
      // packets that follow each yield a verdict, so the result path fills up
      // and the block has to stall its input.
      hold_req_seq++;
      repeat (PRESSURE_PKTS) send_random_packet(1'b1, 0, sent);
    end
    if (saturate) send_random_packet(1'b0, COUNT_LIMIT + 12, sent);
    while (sent < byte_budget) send_random_packet(1'b0, 0, sent);
  endtask

  // This waits until every queued verdict has come out and the pipeline is empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // This writes both address registers. The writes are framed by junk writes to
  // the unused indexes. Enable stays high across the back-to-back writes and
  // drops once at the end.
  task automatic program_regs(input logic [31:0] own, input logic [31:0] probed);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [31:0]          val [4];
    int k;
    idx = '{CFG_SPARE_LO, CFG_OWN_IP, CFG_PROBED_IP, CFG_SPARE_HI};
    val = '{32'($urandom), own, probed, 32'($urandom)};
    for (k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      case (idx[k])
        CFG_OWN_IP:    own_ip = val[k];
        CFG_PROBED_IP: probed_ip = val[k];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // The result side samples each transaction at the clock edge and checks it
  // against the oldest queued verdict. It then picks ready for the next cycle.
  // A hold-off request forces ready low until its hold-off count runs out.
  initial begin : result_sink
    arp_verdict_t exp_v;
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected result: verdict %0d, reply_sender_ip %h",
                 out_ch.verdict, out_ch.reply_sender_ip);
          mismatch_count++;
        end else begin
          exp_v = pending_verdicts.pop_front();
          if (out_ch.verdict !== exp_v.verdict) begin
            $error("verdict: expected %0d, actual %0d", exp_v.verdict, out_ch.verdict);
            mismatch_count++;
          end
          if (out_ch.reply_sender_ip !== exp_v.sender_ip) begin
            $error("reply_sender_ip: expected %h, actual %h",
                   exp_v.sender_ip, out_ch.reply_sender_ip);
            mismatch_count++;
          end
        end
      end
      if (hold_seen != hold_req_seq) begin
        hold_seen = hold_req_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // The watchdog limit allows for the slowest correct run many times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("arp_reply_checker: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    in_ch.valid          <= 1'b0;
    in_ch.pkt_byte       <= '0;
    in_ch.last_byte      <= 1'b0;
    in_ch.link_pkt_class <= '0;
    in_ch.link_hw_type   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_OWN_IP;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The directed table runs on the reset register values, which are both zero.
    tx_idle_pct = 12;
    rx_idle_pct = 73;
    for (i = 0; i < DIR_ROWS; i++) begin
      send_byte(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
    end
    settle();

    // Phase one: the sender idles lightly and the receiver idles heavily.
    program_regs(32'($urandom), 32'($urandom));
    run_packets(PHASE_BYTES, 1'b0, 1'b0);
    settle();

    // Phase two: the sender idles heavily and the receiver idles lightly. Both
    // registers hold all ones.
    tx_idle_pct = 73;
    rx_idle_pct = 12;
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_packets(PHASE_BYTES, 1'b0, 1'b0);
    settle();

    // Phase three: neither side idles. This phase has the receiver hold-off and
    // a packet that runs past the byte counter limit.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_regs(32'h0, 32'($urandom));
    run_packets(FINAL_BYTES, 1'b1, 1'b1);
    settle();

    if (mismatch_count == 0) begin
      $display("arp_reply_checker: match");
    end else begin
      $display("arp_reply_checker: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/arp_rc_pkg.sv
rtl/arp_rc_in_if.sv
rtl/arp_rc_out_if.sv
rtl/arp_rc_parse.sv
rtl/arp_rc_judge.sv
rtl/arp_reply_checker.sv
verif/testbench.sv
